FILE: hw/rtl/sonar_echo_median_filter_top_assert.svh
// Assertion macros shared by the sonar echo median filter RTL.
`ifndef SONAR_ECHO_MEDIAN_FILTER_TOP_ASSERT_SVH
`define SONAR_ECHO_MEDIAN_FILTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Implication checked every clock, off while reset is held.
`define SEMF_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");
// Antecedent in this cycle, consequent in the next.
`define SEMF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define SEMF_ASSERT(label, clk, rstn, prop)
`define SEMF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: hw/rtl/semf_pkg.sv
package semf_pkg;

    localparam int unsigned SPEED_W    = 16;
    localparam int unsigned LIMIT_W    = 16;
    localparam int unsigned INTERVAL_W = 10;
    localparam int unsigned WIDTH_W    = 16;
    localparam int unsigned CM_W       = 16;
    localparam int unsigned MS_W       = 16;
    localparam int unsigned PROD_W     = WIDTH_W + SPEED_W;
    localparam int unsigned LIM_MS_W   = 7;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_SPEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_INTERVAL = 2'd2;

    localparam logic [SPEED_W-1:0]    SPEED_RST    = 16'd2248;
    localparam logic [LIMIT_W-1:0]    LIMIT_RST    = 16'd25000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 10'd60;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_ECHO = 1'b1;

    // floor(x / 1000) = (x * 67109) >> 26, exact for any 16-bit x
    localparam int unsigned DIV1000_MUL_W = 17;
    localparam logic [DIV1000_MUL_W-1:0] DIV1000_MUL = 17'd67109;
    localparam int unsigned DIV1000_SHIFT = 26;
    localparam logic [LIM_MS_W-1:0] TIMEOUT_EXTRA_MS = 7'd5;

    // cm/16 = (width * speed_q16 + 4096) >> 13
    localparam int unsigned DIST_SHIFT = 13;
    localparam logic [PROD_W:0] DIST_ROUND = 33'd4096;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 40;

    typedef struct packed {
        logic            ok;
        logic [CM_W-1:0] cm;
    } semf_sample_t;

    typedef struct packed {
        logic push;  // shift a new sample into the chain, reload probes
        logic step;  // rotate probes one cell, accumulate ranks
    } semf_win_ctrl_t;

endpackage

FILE: hw/rtl/semf_cell.sv
module semf_cell #(
    parameter int unsigned IDX_W   = 3,
    parameter int unsigned RANK_W  = 3,
    parameter int unsigned CELL_ID = 0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  semf_pkg::semf_win_ctrl_t ctrl,
    input  semf_pkg::semf_sample_t   shift_in,
    output semf_pkg::semf_sample_t   shift_out,
    input  semf_pkg::semf_sample_t   probe_in,
    input  logic [IDX_W-1:0]         probe_idx_in,
    output semf_pkg::semf_sample_t   probe_out,
    output logic [IDX_W-1:0]         probe_idx_out,
    output logic [RANK_W-1:0]        rank_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

    logic                      own_ok_reg, own_ok_next;
    logic [semf_pkg::CM_W-1:0] own_cm_reg, own_cm_next;
    logic                      probe_ok_reg, probe_ok_next;
    logic [semf_pkg::CM_W-1:0] probe_cm_reg, probe_cm_next;
    logic [IDX_W-1:0]          probe_idx_reg, probe_idx_next;
    logic [RANK_W-1:0]         rank_reg, rank_next;
    logic                      probe_below;

    // strict order with the cell index as tie break: ranks of valid cells are unique
    assign probe_below = probe_ok_reg && own_ok_reg &&
                         ((probe_cm_reg < own_cm_reg) ||
                          ((probe_cm_reg == own_cm_reg) && (probe_idx_reg < MY_IDX)));

    always_comb begin
        own_ok_next    = own_ok_reg;
        own_cm_next    = own_cm_reg;
        probe_ok_next  = probe_ok_reg;
        probe_cm_next  = probe_cm_reg;
        probe_idx_next = probe_idx_reg;
        rank_next      = rank_reg;
        if (ctrl.push) begin
            own_ok_next    = shift_in.ok;
            own_cm_next    = shift_in.cm;
            probe_ok_next  = shift_in.ok;
            probe_cm_next  = shift_in.cm;
            probe_idx_next = MY_IDX;
            rank_next      = '0;
        end else if (ctrl.step) begin
            probe_ok_next  = probe_in.ok;
            probe_cm_next  = probe_in.cm;
            probe_idx_next = probe_idx_in;
            if (probe_below) begin
                rank_next = rank_reg + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ok_reg   <= 1'b0;
            probe_ok_reg <= 1'b0;
            rank_reg     <= '0;
        end else begin
            own_ok_reg   <= own_ok_next;
            probe_ok_reg <= probe_ok_next;
            rank_reg     <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        own_cm_reg    <= own_cm_next;
        probe_cm_reg  <= probe_cm_next;
        probe_idx_reg <= probe_idx_next;
    end

    assign shift_out.ok    = own_ok_reg;
    assign shift_out.cm    = own_cm_reg;
    assign probe_out.ok    = probe_ok_reg;
    assign probe_out.cm    = probe_cm_reg;
    assign probe_idx_out   = probe_idx_reg;
    assign rank_out        = rank_reg;

endmodule

FILE: hw/rtl/semf_window.sv
module semf_window #(
    parameter int unsigned WINDOW = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  semf_pkg::semf_win_ctrl_t ctrl,
    input  semf_pkg::semf_sample_t   sample_in,
    input  logic [$clog2(WINDOW+1)-1:0] fill,
    output semf_pkg::semf_sample_t   median
);

    localparam int unsigned IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned RANK_W = $clog2(WINDOW + 1);

    semf_pkg::semf_sample_t own   [WINDOW];
    semf_pkg::semf_sample_t probe [WINDOW];
    logic [IDX_W-1:0]       pidx  [WINDOW];
    logic [RANK_W-1:0]      rank  [WINDOW];
    logic [WINDOW-1:0]      valid_vec;

    logic [RANK_W-1:0]         n_valid;
    logic [RANK_W-1:0]         mid_rank;
    logic [semf_pkg::CM_W-1:0] pick;
    logic                      med_ok;

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        semf_cell #(
            .IDX_W  (IDX_W),
            .RANK_W (RANK_W),
            .CELL_ID(i)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .shift_in     ((i == 0) ? sample_in : own[(i + WINDOW - 1) % WINDOW]),
            .shift_out    (own[i]),
            .probe_in     (probe[(i + WINDOW - 1) % WINDOW]),
            .probe_idx_in (pidx[(i + WINDOW - 1) % WINDOW]),
            .probe_out    (probe[i]),
            .probe_idx_out(pidx[i]),
            .rank_out     (rank[i])
        );
        assign valid_vec[i] = own[i].ok;
    end

    assign n_valid  = RANK_W'($countones(valid_vec));
    assign mid_rank = n_valid >> 1;
    assign med_ok   = (n_valid != '0) && ({1'b0, n_valid, 1'b0} >= {2'b00, fill});

    always_comb begin
        pick = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (own[i].ok && (rank[i] == mid_rank)) begin
                pick = pick | own[i].cm;
            end
        end
    end

    assign median.ok = med_ok;
    assign median.cm = med_ok ? pick : '0;

endmodule

FILE: hw/rtl/sonar_echo_median_filter_top.sv
// Sequence: an accepted item passes S_MUL, S_DEC and S_OUT; an item that pushes a
//   sample also passes S_RANK (WINDOW ranking steps of the probe rotation through
//   the cell row) and S_MED. A new item is taken only in S_IDLE, so not before the
//   last one is handed to the output register; a stalled output holds the next item in OUT.
// Reset: aresetn synchronous, active low; registers to defaults, window empty.
`include "sonar_echo_median_filter_top_assert.svh"

module sonar_echo_median_filter_top #(
    parameter int unsigned WINDOW = 5  // filter window length, 1..31
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // config write port, no read-back
    input  logic                                    cfg_wr_en,
    input  logic [semf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [semf_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    // input stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [semf_pkg::IN_TDATA_W-1:0]         s_tdata,  // [15:0] echo_width_us
    input  logic                                    s_tuser,  // [0] func
    // result stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // [0] ping_start, [1] sample_taken, [2] sample_ok, [18:3] sample_cm_x16,
    // [19] median_ok, [35:20] median_cm_x16, [39:36] zero
    output logic [semf_pkg::OUT_TDATA_W-1:0]        m_tdata
);

    localparam int unsigned FILL_W = $clog2(WINDOW + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an input transaction
    localparam logic [2:0] S_MUL  = 3'd1;  // distance and timeout products
    localparam logic [2:0] S_DEC  = 3'd2;  // timer / echo decision, push sample
    localparam logic [2:0] S_RANK = 3'd3;  // probes rotate through the cell row
    localparam logic [2:0] S_MED  = 3'd4;  // capture median
    localparam logic [2:0] S_OUT  = 3'd5;  // hand result to output register

    logic [2:0] state_reg, state_next;

    // configuration registers
    logic [semf_pkg::SPEED_W-1:0]    cfg_speed_reg;
    logic [semf_pkg::LIMIT_W-1:0]    cfg_limit_reg;
    logic [semf_pkg::INTERVAL_W-1:0] cfg_interval_reg;

    // captured item and products
    logic                             func_reg;
    logic [semf_pkg::WIDTH_W-1:0]     width_reg;
    logic [semf_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [semf_pkg::LIM_MS_W-1:0]    lim_ms_reg, lim_ms_next;
    logic [semf_pkg::PROD_W:0]        lim_prod;

    // ping scheduler state
    logic                             awaiting_reg, awaiting_next;
    logic [semf_pkg::MS_W-1:0]        ms_reg, ms_next;
    logic [semf_pkg::MS_W-1:0]        ms_inc;
    logic [semf_pkg::LIM_MS_W-1:0]    timeout_ms;

    // window bookkeeping
    logic [FILL_W-1:0]                fill_reg, fill_next;
    logic [FILL_W-1:0]                step_reg, step_next;

    // per-item result fields
    logic                             ping_reg, ping_next;
    logic                             taken_reg, taken_next;
    logic                             ok_reg, ok_next;
    logic [semf_pkg::CM_W-1:0]        cm_reg, cm_next;
    logic                             filt_ok_reg, filt_ok_next;
    logic [semf_pkg::CM_W-1:0]        filt_cm_reg, filt_cm_next;

    logic                             m_tvalid_reg, m_tvalid_next;
    logic [semf_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // distance arithmetic
    logic [semf_pkg::PROD_W:0]        dist_rnd;
    logic [semf_pkg::PROD_W-semf_pkg::DIST_SHIFT:0] dist_full;
    logic [semf_pkg::CM_W-1:0]        dist_sat;
    logic                             echo_good;

    semf_pkg::semf_win_ctrl_t         win_ctrl;
    semf_pkg::semf_sample_t           win_sample;
    semf_pkg::semf_sample_t           win_median;

    logic in_xact;
    logic out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xact  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------------------------------------------------------------
    // Configuration writes; an index past the list is dropped.
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_speed_reg    <= semf_pkg::SPEED_RST;
            cfg_limit_reg    <= semf_pkg::LIMIT_RST;
            cfg_interval_reg <= semf_pkg::INTERVAL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                semf_pkg::CFG_SOUND_SPEED:   cfg_speed_reg    <= cfg_wdata;
                semf_pkg::CFG_ECHO_LIMIT:    cfg_limit_reg    <= cfg_wdata;
                semf_pkg::CFG_PING_INTERVAL:
                    cfg_interval_reg <= cfg_wdata[semf_pkg::INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Products, one multiplier each, registered before use.
    // echo limit in whole ms via reciprocal multiply (no divider).
    // ---------------------------------------------------------------------
    assign prod_next   = semf_pkg::PROD_W'(width_reg) * semf_pkg::PROD_W'(cfg_speed_reg);
    assign lim_prod    = (semf_pkg::PROD_W + 1)'(cfg_limit_reg) *
                         (semf_pkg::PROD_W + 1)'(semf_pkg::DIV1000_MUL);
    assign lim_ms_next = lim_prod[semf_pkg::PROD_W:semf_pkg::DIV1000_SHIFT];

    // cm/16 with round half up, saturated to 16 bits
    assign dist_rnd  = {1'b0, prod_reg} + semf_pkg::DIST_ROUND;
    assign dist_full = dist_rnd[semf_pkg::PROD_W:semf_pkg::DIST_SHIFT];
    assign dist_sat  = (|dist_full[semf_pkg::PROD_W-semf_pkg::DIST_SHIFT:semf_pkg::CM_W])
                       ? '1 : dist_full[semf_pkg::CM_W-1:0];
    assign echo_good = (width_reg != '0) && (width_reg <= cfg_limit_reg);

    assign ms_inc     = (ms_reg == '1) ? ms_reg : ms_reg + semf_pkg::MS_W'(1);
    assign timeout_ms = lim_ms_reg + semf_pkg::TIMEOUT_EXTRA_MS;

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        awaiting_next = awaiting_reg;
        ms_next       = ms_reg;
        fill_next     = fill_reg;
        step_next     = step_reg;
        ping_next     = ping_reg;
        taken_next    = taken_reg;
        ok_next       = ok_reg;
        cm_next       = cm_reg;
        filt_ok_next  = filt_ok_reg;
        filt_cm_next  = filt_cm_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        win_ctrl      = '0;
        win_sample    = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_xact) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                state_next = S_DEC;
            end
            S_DEC: begin
                ping_next  = 1'b0;
                taken_next = 1'b0;
                ok_next    = 1'b0;
                cm_next    = '0;
                if (func_reg == semf_pkg::FUNC_TICK) begin
                    if (awaiting_reg &&
                        (ms_inc > semf_pkg::MS_W'(timeout_ms))) begin
                        // unanswered ping: log an invalid sample
                        ms_next       = ms_inc;
                        awaiting_next = 1'b0;
                        taken_next    = 1'b1;
                    end else if (ms_inc >= semf_pkg::MS_W'(cfg_interval_reg)) begin
                        ms_next       = '0;
                        awaiting_next = 1'b1;
                        ping_next     = 1'b1;
                    end else begin
                        ms_next = ms_inc;
                    end
                end else if (awaiting_reg) begin
                    awaiting_next = 1'b0;
                    taken_next    = 1'b1;
                    ok_next       = echo_good;
                    cm_next       = echo_good ? dist_sat : '0;
                end
                if (taken_next) begin
                    win_ctrl.push = 1'b1;
                    win_sample.ok = ok_next;
                    win_sample.cm = cm_next;
                    if (fill_reg != FILL_W'(WINDOW)) begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    step_next  = '0;
                    state_next = S_RANK;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_RANK: begin
                win_ctrl.step = 1'b1;
                step_next     = step_reg + FILL_W'(1);
                if (step_reg == FILL_W'(WINDOW - 1)) begin
                    state_next = S_MED;
                end
            end
            S_MED: begin
                filt_ok_next = win_median.ok;
                filt_cm_next = win_median.cm;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000,
                                     filt_ok_reg ? filt_cm_reg : {semf_pkg::CM_W{1'b0}},
                                     filt_ok_reg, cm_reg, ok_reg, taken_reg, ping_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            awaiting_reg <= 1'b0;
            ms_reg       <= '0;
            fill_reg     <= '0;
            step_reg     <= '0;
            filt_ok_reg  <= 1'b0;
            filt_cm_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            awaiting_reg <= awaiting_next;
            ms_reg       <= ms_next;
            fill_reg     <= fill_next;
            step_reg     <= step_next;
            filt_ok_reg  <= filt_ok_next;
            filt_cm_reg  <= filt_cm_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (in_xact) begin
            func_reg  <= s_tuser;
            width_reg <= s_tdata[semf_pkg::WIDTH_W-1:0];
        end
        prod_reg    <= prod_next;
        lim_ms_reg  <= lim_ms_next;
        ping_reg    <= ping_next;
        taken_reg   <= taken_next;
        ok_reg      <= ok_next;
        cm_reg      <= cm_next;
        m_tdata_reg <= m_tdata_next;
    end

    // ---------------------------------------------------------------------
    // Sample window: row of cells, ranks built by rotating probes
    // ---------------------------------------------------------------------
    semf_window #(
        .WINDOW(WINDOW)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (win_ctrl),
        .sample_in(win_sample),
        .fill     (fill_reg),
        .median   (win_median)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `SEMF_ASSERT(a_ping_xor_sample, aclk, aresetn, m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    `SEMF_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= FILL_W'(WINDOW))
    `SEMF_ASSERT(a_median_needs_fill, aclk, aresetn, (m_tvalid && m_tdata[19]) |-> (fill_reg != '0))
    `SEMF_ASSERT_NEXT(a_accept_starts, aclk, aresetn, in_xact, state_reg == S_MUL)
    `SEMF_ASSERT_NEXT(a_ping_arms, aclk, aresetn, (state_reg == S_DEC) && ping_next, awaiting_reg && (ms_reg == '0))

endmodule

FILE: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import semf_pkg::*;

    // Ring depth of the filter under test; the DUT gets the same value.
    localparam int unsigned RING_DEPTH = 5;
    // Register index past the end of the list; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    // Cycles allowed after the last result before the run ends or config changes.
    // It covers the longest pass of an item through the DUT with ample margin.
    localparam int unsigned DRAIN_CYCLES = 4 * (RING_DEPTH + 5);
    // Length of the long receiver hold-off in the backpressure test.
    localparam int unsigned HOLD_CYCLES = 300;
    // Watchdog: cycles with no transaction on either channel. The worst legal
    // quiet stretch is the hold-off plus a random receiver stall; this is
    // many times that.
    localparam int unsigned QUIET_LIMIT = 5000;
    // Cap on printed mismatch lines; every mismatch is still counted.
    localparam int unsigned PRINT_CAP = 100;

    // One result transaction, laid out exactly as m_tdata (MSB first here):
    // [0] ping_start, [1] sample_taken, [2] sample_ok, [18:3] sample_cm_x16,
    // [19] median_ok, [35:20] median_cm_x16, [39:36] zero
    typedef struct packed {
        logic [3:0]      pad;
        logic [CM_W-1:0] median_cm;
        logic            median_ok;
        logic [CM_W-1:0] sample_cm;
        logic            sample_ok;
        logic            sample_taken;
        logic            ping_start;
    } ranger_result_t;

    // ------------------------------------------------------------------
    // DUT signals. Every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;  // [15:0] echo_width_us
    logic                   s_tuser   = 1'b0;  // [0] func
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;  // see ranger_result_t

    sonar_echo_median_filter_top #(
        .WINDOW(RING_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Ranger predictor: its own copy of config and state.
    // ------------------------------------------------------------------
    logic [SPEED_W-1:0]    spd_cfg;
    logic [LIMIT_W-1:0]    lim_cfg;
    logic [INTERVAL_W-1:0] ivl_cfg;

    logic                  echo_pending;   // ping fired, no echo or timeout yet
    logic [MS_W-1:0]       ms_elapsed;     // ms since last ping, saturating
    logic [CM_W-1:0]       ring_val [RING_DEPTH];
    logic                  ring_ok  [RING_DEPTH];
    int unsigned           ring_wr;
    int unsigned           ring_fill;
    logic [CM_W-1:0]       median_val;
    logic                  median_good;

    ranger_result_t expected_results[$];

    // Traffic shaping knobs, set per test.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    // Hold-off handshake between the test tasks and the receiver process.
    int unsigned hold_asked = 0;
    int unsigned hold_done  = 0;
    int unsigned hold_left  = 0;

    int unsigned error_count  = 0;
    int unsigned result_count = 0;
    int unsigned quiet_cycles = 0;

    function automatic void reset_predictor();
        spd_cfg      = SPEED_RST;
        lim_cfg      = LIMIT_RST;
        ivl_cfg      = INTERVAL_RST;
        echo_pending = 1'b0;
        ms_elapsed   = '0;
        for (int i = 0; i < RING_DEPTH; i++) begin
            ring_val[i] = '0;
            ring_ok[i]  = 1'b0;
        end
        ring_wr     = 0;
        ring_fill   = 0;
        median_val  = '0;
        median_good = 1'b0;
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SOUND_SPEED:   spd_cfg = data[SPEED_W-1:0];
            CFG_ECHO_LIMIT:    lim_cfg = data[LIMIT_W-1:0];
            CFG_PING_INTERVAL: ivl_cfg = data[INTERVAL_W-1:0];
            default: ;  // out-of-range index: no register changes
        endcase
    endfunction

    // Upper median over the valid entries, in write order of the ring slots.
    function automatic void update_median();
        logic [CM_W-1:0] sorted [RING_DEPTH];
        logic [CM_W-1:0] key;
        int unsigned     n;
        int unsigned     i;
        int unsigned     j;
        n = 0;
        for (i = 0; i < ring_fill; i++) begin
            if (ring_ok[i]) begin
                key = ring_val[i];
                j   = n;
                while (j > 0 && sorted[j-1] > key) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = key;
                n++;
            end
        end
        if (n == 0 || n * 2 < ring_fill) begin
            median_good = 1'b0;
            median_val  = '0;
        end else begin
            median_good = 1'b1;
            median_val  = sorted[n/2];
        end
    endfunction

    function automatic void push_ring(input logic ok, input logic [CM_W-1:0] cm);
        ring_val[ring_wr] = ok ? cm : '0;
        ring_ok[ring_wr]  = ok;
        ring_wr           = (ring_wr + 1 >= RING_DEPTH) ? 0 : ring_wr + 1;
        if (ring_fill < RING_DEPTH)
            ring_fill++;
        update_median();
    endfunction

    function automatic ranger_result_t predict_ranger_step(input logic func,
                                                          input logic [WIDTH_W-1:0] width);
        ranger_result_t   r;
        int unsigned      timeout_ms;
        longint unsigned  cm_full;
        r = '0;
        if (func == FUNC_TICK) begin
            if (ms_elapsed != '1)
                ms_elapsed++;
            timeout_ms = 32'(lim_cfg) / 1000 + 32'(TIMEOUT_EXTRA_MS);
            if (echo_pending && 32'(ms_elapsed) > timeout_ms) begin
                // unanswered ping: log an invalid sample
                echo_pending   = 1'b0;
                r.sample_taken = 1'b1;
                push_ring(1'b0, '0);
            end else if (32'(ms_elapsed) >= 32'(ivl_cfg)) begin
                ms_elapsed   = '0;
                echo_pending = 1'b1;
                r.ping_start = 1'b1;
            end
        end else if (echo_pending) begin
            echo_pending   = 1'b0;
            r.sample_taken = 1'b1;
            if (width != 0 && width <= lim_cfg) begin
                cm_full     = (64'(width) * 64'(spd_cfg) + 64'd4096) >> DIST_SHIFT;
                r.sample_ok = 1'b1;
                r.sample_cm = (cm_full > 64'hFFFF) ? 16'hFFFF : cm_full[CM_W-1:0];
            end
            push_ring(r.sample_ok, r.sample_cm);
        end
        r.median_ok = median_good;
        r.median_cm = median_good ? median_val : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp);
        if (error_count < PRINT_CAP)
            $display("mismatch @%0t result %0d %s: got %h exp %h",
                     $realtime, result_count, what, got, exp);
        error_count++;
    endtask

    // Result channel sampled at the edge: m_tready is driven by NBA, so the
    // values read here are the ones the DUT saw.
    always @(posedge aclk) begin
        ranger_result_t got;
        ranger_result_t exp;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got = ranger_result_t'(m_tdata);
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction", m_tdata[15:0], 16'h0);
            end else begin
                exp = expected_results.pop_front();
                if (got.ping_start !== exp.ping_start)
                    report_mismatch("ping_start", 16'(got.ping_start), 16'(exp.ping_start));
                if (got.sample_taken !== exp.sample_taken)
                    report_mismatch("sample_taken", 16'(got.sample_taken),
                                    16'(exp.sample_taken));
                if (got.sample_ok !== exp.sample_ok)
                    report_mismatch("sample_ok", 16'(got.sample_ok), 16'(exp.sample_ok));
                if (got.sample_cm !== exp.sample_cm)
                    report_mismatch("sample_cm_x16", got.sample_cm, exp.sample_cm);
                if (got.median_ok !== exp.median_ok)
                    report_mismatch("median_ok", 16'(got.median_ok), 16'(exp.median_ok));
                if (got.median_cm !== exp.median_cm)
                    report_mismatch("median_cm_x16", got.median_cm, exp.median_cm);
                if (got.pad !== exp.pad)
                    report_mismatch("pad bits", 16'(got.pad), 16'(exp.pad));
            end
            result_count++;
        end
    end

    // Receiver: random ready, or a counted hold-off when a test asks for one.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_done != hold_asked) begin
            hold_done <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a run that stops moving is a failure.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offer one item, with random idle cycles first; on acceptance the
    // predictor steps. tvalid stays high on return so a following item
    // can go out back to back.
    task automatic send_item(input logic func, input logic [WIDTH_W-1:0] width);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= width;
        @(posedge aclk);
        while (s_tready !== 1'b1)
            @(posedge aclk);
        expected_results.push_back(predict_ranger_step(func, width));
    endtask

    // Sender pauses until every expected result has arrived, then lets the
    // pipeline settle.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers plus the unused index, one per cycle. The
    // interval gets random upper data bits to check masking.
    task automatic set_config(input logic [SPEED_W-1:0] spd, input logic [LIMIT_W-1:0] lim,
                              input logic [INTERVAL_W-1:0] ivl);
        logic [CFG_IDX_W-1:0]  idx  [4];
        logic [CFG_DATA_W-1:0] data [4];
        idx[0]  = CFG_SOUND_SPEED;   data[0] = spd;
        idx[1]  = CFG_ECHO_LIMIT;    data[1] = lim;
        idx[2]  = CFG_PING_INTERVAL; data[2] = {6'($urandom), ivl};
        idx[3]  = CFG_UNUSED_IDX;    data[3] = 16'($urandom);
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= data[i];
            @(posedge aclk);
            apply_config(idx[i], data[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Echo width biased toward the interesting spots around the limit.
    function automatic logic [WIDTH_W-1:0] pick_echo_width();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 60 && lim_cfg != 0)
            return 16'($urandom_range(32'(lim_cfg), 1));
        if (k < 70)
            return '0;
        if (k < 80)
            return (lim_cfg == '1) ? lim_cfg : 16'($urandom_range(65535, 32'(lim_cfg) + 1));
        if (k < 85)
            return lim_cfg;
        return 16'($urandom);
    endfunction

    // Mostly well-formed ping/echo or ping/timeout sequences, some noise.
    // Echoes that arrive with no ping pending do not count toward n_items.
    task automatic drive_random_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned cap;
        logic        func;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 75) begin
                cap = 0;
                while (!echo_pending && cap < 40) begin
                    send_item(FUNC_TICK, 16'($urandom));
                    sent++;
                    cap++;
                end
                if (echo_pending) begin
                    if ($urandom_range(99) < 80) begin
                        send_item(FUNC_ECHO, pick_echo_width());
                        sent++;
                    end else begin
                        // no echo: tick on until timeout (or a re-ping keeps it pending)
                        cap = 0;
                        while (echo_pending && cap < 80) begin
                            send_item(FUNC_TICK, 16'($urandom));
                            sent++;
                            cap++;
                        end
                    end
                end
            end else begin
                func = 1'($urandom_range(1));
                if (func == FUNC_TICK || echo_pending)
                    sent++;
                send_item(func, 16'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: 60 ms interval, so a few ticks give no ping; an echo with
    // nothing pending is ignored and only repeats the (invalid) median.
    task automatic test_defaults_after_reset();
        send_item(FUNC_ECHO, 16'd12345);
        send_item(FUNC_TICK, 16'hFFFF);
        send_item(FUNC_TICK, 16'h0000);
    endtask

    // Zero echo, overlong echo, echo exactly at the limit, smallest echo,
    // and a re-ping while still waiting for an echo.
    task automatic test_echo_validity();
        wait_results_done();
        set_config(16'd2248, 16'd25000, 10'd1);
        send_item(FUNC_TICK, 16'h0);
        send_item(FUNC_ECHO, 16'd0);
        send_item(FUNC_TICK, 16'h0);
        send_item(FUNC_ECHO, 16'hFFFF);
        send_item(FUNC_TICK, 16'h0);
        send_item(FUNC_TICK, 16'h0);      // interval elapsed again: new ping
        send_item(FUNC_ECHO, 16'd25000);
        send_item(FUNC_TICK, 16'h0);
        send_item(FUNC_ECHO, 16'd1);
    endtask

    // Widest echo at full speed saturates the distance; zero interval pings
    // on every tick.
    task automatic test_saturation_extremes();
        wait_results_done();
        set_config(16'hFFFF, 16'hFFFF, 10'd0);
        send_item(FUNC_TICK, 16'h5555);
        send_item(FUNC_ECHO, 16'hFFFF);
        send_item(FUNC_TICK, 16'hAAAA);
        send_item(FUNC_ECHO, 16'd1);
    endtask

    // Zero speed: valid samples of distance zero, and an invalid echo over the limit.
    task automatic test_zero_speed();
        wait_results_done();
        set_config(16'd0, 16'd1000, 10'd0);
        send_item(FUNC_TICK, 16'h0);
        send_item(FUNC_ECHO, 16'd777);
        send_item(FUNC_TICK, 16'h0);
        send_item(FUNC_ECHO, 16'd1001);
        send_item(FUNC_TICK, 16'h0);
    endtask

    // Random traffic over four settings; long_interval puts the interval at
    // its field maximum in the last setting, which then gets few items.
    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                       input bit long_interval);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int k = 0; k < 4; k++) begin
            wait_results_done();
            case (k)
                // small limit (timeout 5..8 ms), interval 6..12 ms: timeouts happen when the interval is above it
                0: set_config(16'($urandom), 16'($urandom_range(3000)),
                              10'($urandom_range(12, 6)));
                1: set_config(16'd1, 16'd1, 10'd1);
                2: set_config(16'hFFFF, 16'hFFFF, 10'($urandom_range(15)));
                default: set_config(16'($urandom), 16'($urandom),
                                    long_interval ? 10'h3FF : 10'($urandom_range(20)));
            endcase
            drive_random_phase((k == 3 && long_interval) ? 60 : 160);
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the block fills and drops s_tready. Zero limit: every echo invalid.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_results_done();
        set_config(16'($urandom), 16'd0, 10'd7);
        hold_asked <= hold_asked + 1;
        drive_random_phase(40);
    endtask

    initial begin
        reset_predictor();
        send_idle_pct = 22;
        recv_idle_pct = 85;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_defaults_after_reset();
        test_echo_validity();
        test_saturation_extremes();
        test_zero_speed();
        test_random_traffic(22, 85, 1'b1);
        test_random_traffic(85, 22, 1'b0);
        test_random_traffic(0, 0, 1'b0);
        test_backpressure();

        wait_results_done();
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/semf_pkg.sv
hw/rtl/semf_cell.sv
hw/rtl/semf_window.sv
hw/rtl/sonar_echo_median_filter_top.sv
verif/tb_top.sv
